// File: src/bhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhq_pkg: shared types and codes of the binary max-heap queue
// Entry layout, request codes, store control and result bundle.
// ----------------------------------------------------------------------------
package bhq_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam int unsigned COUNT_OUT_W = 5;

   typedef struct packed {
      logic        [15:0] tag;
      logic signed [15:0] prim;
      logic signed [15:0] sec;
   } entry_type;

   typedef struct packed {
      logic we;
      logic re;
   } store_cmd_type;

   typedef struct packed {
      logic                   ok;
      logic                   head_valid;
      entry_type              head;
      logic [COUNT_OUT_W-1:0] count;
   } result_type;

endpackage

// File: src/bhq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhq_req_if: request channel of the heap queue
// Valid/ready handshake carrying a push or pop request.
// ----------------------------------------------------------------------------
interface bhq_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic        [15:0] item_tag;
   logic signed [15:0] primary_priority;
   logic signed [15:0] secondary_priority;

   modport source (
      output valid, cmd, item_tag, primary_priority, secondary_priority,
      input  ready
   );
   modport sink (
      input  valid, cmd, item_tag, primary_priority, secondary_priority,
      output ready
   );
endinterface

// File: src/bhq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhq_rsp_if: response channel of the heap queue
// Valid/ready handshake carrying status, head entry and entry count.
// ----------------------------------------------------------------------------
interface bhq_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic               head_valid;
   logic        [15:0] head_tag;
   logic signed [15:0] head_primary;
   logic signed [15:0] head_secondary;
   logic        [4:0]  entry_count_out;

   modport source (
      output valid, ok, head_valid, head_tag, head_primary, head_secondary,
             entry_count_out,
      input  ready
   );
   modport sink (
      input  valid, ok, head_valid, head_tag, head_primary, head_secondary,
             entry_count_out,
      output ready
   );
endinterface

// File: src/bhq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhq_store: heap entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhq_store #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                           clock,
   input  bhq_pkg::store_cmd_type         cmd,
   input  logic [$clog2(CAPACITY)-1:0]    waddr,
   input  bhq_pkg::entry_type             wdata,
   input  logic [$clog2(CAPACITY)-1:0]    raddr,
   output bhq_pkg::entry_type             rdata
);
   bhq_pkg::entry_type mem [CAPACITY];
   bhq_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/bhq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhq_ctrl: sift sequencer of the heap queue
// Walks the heap one level at a time through the entry memory.
// ----------------------------------------------------------------------------
module bhq_ctrl #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  bhq_pkg::entry_type             req_entry,
   output logic                           done,
   input  logic                           rsp_free,
   output bhq_pkg::result_type            result,
   output bhq_pkg::store_cmd_type         store_cmd,
   output logic [$clog2(CAPACITY)-1:0]    store_waddr,
   output bhq_pkg::entry_type             store_wdata,
   output logic [$clog2(CAPACITY)-1:0]    store_raddr,
   input  bhq_pkg::entry_type             store_rdata
);
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] ONE  = CW'(1);
   localparam logic [CW-1:0] TWO  = CW'(2);
   localparam logic [CW-1:0] FULL = CW'(CAPACITY);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_UP      = 7'b0000010,
      ST_DN_LAST = 7'b0000100,
      ST_DN_L    = 7'b0001000,
      ST_DN_R    = 7'b0010000,
      ST_WR_MV   = 7'b0100000,
      ST_RESP    = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      at_ff, at_in;
   logic               ok_ff, ok_in;
   bhq_pkg::entry_type mv_ff, mv_in;
   bhq_pkg::entry_type lt_ff, lt_in;
   bhq_pkg::entry_type head_ff, head_in;

   logic [CW-1:0]      wslot, rslot, wslot_m1, rslot_m1;
   logic [CW-1:0]      parent_slot, grand_slot, big_slot;
   logic [CW:0]        left_c, right_c, n_ext, big_left_c;
   logic               take_right;
   bhq_pkg::entry_type big_entry;

   assign parent_slot = at_ff >> 1;
   assign grand_slot  = at_ff >> 2;
   assign left_c      = {at_ff, 1'b0};
   assign right_c     = {at_ff, 1'b1};
   assign n_ext       = {1'b0, count_ff};
   assign take_right  = !($signed(lt_ff.prim) > $signed(store_rdata.prim));
   assign big_entry   = take_right ? store_rdata : lt_ff;
   assign big_slot    = take_right ? right_c[CW-1:0] : left_c[CW-1:0];
   assign big_left_c  = {big_slot, 1'b0};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      at_in       = at_ff;
      ok_in       = ok_ff;
      mv_in       = mv_ff;
      lt_in       = lt_ff;
      store_cmd   = '0;
      wslot       = at_ff;
      store_wdata = mv_ff;
      rslot       = ONE;
      req_ready   = 1'b0;
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == bhq_pkg::CMD_PUSH) begin
                  if (count_ff == FULL) begin
                     ok_in    = 1'b0;
                     state_in = ST_RESP;
                  end else begin
                     ok_in    = 1'b1;
                     count_in = count_ff + ONE;
                     at_in    = count_ff + ONE;
                     mv_in    = req_entry;
                     if (count_ff == '0) begin
                        store_cmd.we = 1'b1;
                        wslot        = ONE;
                        store_wdata  = req_entry;
                        state_in     = ST_RESP;
                     end else begin
                        store_cmd.re = 1'b1;
                        rslot        = (count_ff + ONE) >> 1;
                        state_in     = ST_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     ok_in    = 1'b0;
                     state_in = ST_RESP;
                  end else begin
                     ok_in    = 1'b1;
                     count_in = count_ff - ONE;
                     if (count_ff == ONE) begin
                        state_in = ST_RESP;
                     end else begin
                        store_cmd.re = 1'b1;
                        rslot        = count_ff;
                        state_in     = ST_DN_LAST;
                     end
                  end
               end
            end
         end
         ST_UP: begin
            store_cmd.we = 1'b1;
            if ($signed(mv_ff.prim) > $signed(store_rdata.prim)) begin
               store_wdata = store_rdata;
               at_in       = parent_slot;
               if (parent_slot == ONE) begin
                  state_in = ST_WR_MV;
               end else begin
                  store_cmd.re = 1'b1;
                  rslot        = grand_slot;
               end
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DN_LAST: begin
            mv_in = store_rdata;
            at_in = ONE;
            if (count_ff < TWO) begin
               store_cmd.we = 1'b1;
               wslot        = ONE;
               store_wdata  = store_rdata;
               state_in     = ST_RESP;
            end else begin
               store_cmd.re = 1'b1;
               rslot        = TWO;
               state_in     = ST_DN_L;
            end
         end
         ST_DN_L: begin
            lt_in = store_rdata;
            if (right_c > n_ext) begin
               store_cmd.we = 1'b1;
               if ($signed(mv_ff.prim) < $signed(store_rdata.prim)) begin
                  store_wdata = store_rdata;
                  at_in       = left_c[CW-1:0];
                  state_in    = ST_WR_MV;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               store_cmd.re = 1'b1;
               rslot        = right_c[CW-1:0];
               state_in     = ST_DN_R;
            end
         end
         ST_DN_R: begin
            store_cmd.we = 1'b1;
            if ($signed(mv_ff.prim) < $signed(big_entry.prim)) begin
               store_wdata = big_entry;
               at_in       = big_slot;
               if (big_left_c > n_ext) begin
                  state_in = ST_WR_MV;
               end else begin
                  store_cmd.re = 1'b1;
                  rslot        = big_left_c[CW-1:0];
                  state_in     = ST_DN_L;
               end
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WR_MV: begin
            store_cmd.we = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            done = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      head_in = head_ff;
      if (store_cmd.we && wslot == ONE) begin
         head_in = store_wdata;
      end
   end

   assign wslot_m1    = wslot - ONE;
   assign rslot_m1    = rslot - ONE;
   assign store_waddr = wslot_m1[AW-1:0];
   assign store_raddr = rslot_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      at_ff   <= at_in;
      ok_ff   <= ok_in;
      mv_ff   <= mv_in;
      lt_ff   <= lt_in;
      head_ff <= head_in;
   end

   always_comb begin
      result.ok         = ok_ff;
      result.head_valid = (count_ff != '0);
      result.head       = (count_ff != '0) ? head_ff : '0;
      result.count      = bhq_pkg::COUNT_OUT_W'(count_ff);
   end
endmodule

// File: src/binary_max_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue: priority queue on a binary max-heap
// Push and pop requests on req_chan, one response per request on rsp_chan.
// ----------------------------------------------------------------------------
// A request with cmd push stores the entry and sifts it up; cmd pop removes
// the head and sifts the last entry down from the root. Ordering uses the
// primary priority only; on equal children the right child is taken.
// Each response gives ok (0 for a push into a full queue or a pop from an
// empty one), the head entry after the request (zero when empty) and the
// entry count.
// A refused request, a push into an empty queue or a pop of the last entry
// goes straight to the response. A push reads the parent and moves the entry
// up one level per step; a pop reads the last entry, then reads the left and
// right child of each level in turn through the single read port of the entry
// memory. The next request can be taken in the cycle after the response loads.
// One request is in work at a time. The response sits in an output
// register, so a new request is taken while the last response waits.
// When rsp_chan stalls with a response still held, a finished request waits
// until the register frees.
// Reset empties the queue at once; the memory itself needs no clearing.
// ----------------------------------------------------------------------------
module binary_max_heap_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic     clock,
   input  logic     reset,
   bhq_req_if.sink   req_chan,
   bhq_rsp_if.source rsp_chan
);
   localparam int unsigned AW = $clog2(CAPACITY);

   bhq_pkg::entry_type     req_entry;
   bhq_pkg::result_type    result;
   bhq_pkg::result_type    rsp_ff, rsp_in;
   bhq_pkg::store_cmd_type store_cmd;
   bhq_pkg::entry_type     store_wdata, store_rdata;
   logic [AW-1:0]          store_waddr, store_raddr;
   logic                   ready;
   logic                   done;
   logic                   rsp_free;
   logic                   rsp_valid_ff, rsp_valid_in;

   assign req_entry.tag  = req_chan.item_tag;
   assign req_entry.prim = req_chan.primary_priority;
   assign req_entry.sec  = req_chan.secondary_priority;
   assign req_chan.ready = ready;

   bhq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (ready),
      .req_cmd     (req_chan.cmd),
      .req_entry   (req_entry),
      .done        (done),
      .rsp_free    (rsp_free),
      .result      (result),
      .store_cmd   (store_cmd),
      .store_waddr (store_waddr),
      .store_wdata (store_wdata),
      .store_raddr (store_raddr),
      .store_rdata (store_rdata)
   );

   bhq_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock (clock),
      .cmd   (store_cmd),
      .waddr (store_waddr),
      .wdata (store_wdata),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done && rsp_free) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.ok              = rsp_ff.ok;
   assign rsp_chan.head_valid      = rsp_ff.head_valid;
   assign rsp_chan.head_tag        = rsp_ff.head.tag;
   assign rsp_chan.head_primary    = rsp_ff.head.prim;
   assign rsp_chan.head_secondary  = rsp_ff.head.sec;
   assign rsp_chan.entry_count_out = rsp_ff.count;
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: push/pop checker for binary_max_heap_queue
// Drives a directed table of push and pop requests, then random requests in
// phases of sender idling and receiver stalling, with a long response
// hold-off and a full drain. Each response is checked field by field against
// the directed row's result if known, else a heap predictor beside the block.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned HEAP_DEPTH      = 16;
   localparam int unsigned PHASE_ITEMS     = 400;
   localparam int unsigned PRESSURE_ITEMS  = 40;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES    = 40;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned DIRECTED_ROWS   = 23;

   typedef struct packed {
      logic               cmd;
      bhq_pkg::entry_type item;
   } heap_request_type;

   typedef struct packed {
      heap_request_type    req;
      logic                known;
      bhq_pkg::result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   bhq_req_if req_chan ();
   bhq_rsp_if rsp_chan ();

   binary_max_heap_queue #(
      .CAPACITY (HEAP_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bhq_pkg::entry_type  heap_slots [1:HEAP_DEPTH];
   int unsigned         heap_count = 0;
   bhq_pkg::result_type rsp_expected_q [$];
   int unsigned         mismatches = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         hold_requests = 0;
   int unsigned         cycle_count = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{bhq_pkg::CMD_POP,  '{16'h0000, 16'sh0000, 16'sh0000}}, 1'b1,
        '{1'b0, 1'b0, '{16'h0000, 16'sh0000, 16'sh0000}, 5'd0}},
      '{'{bhq_pkg::CMD_PUSH, '{16'hFFFF, 16'sh7FFF, 16'sh8000}}, 1'b1,
        '{1'b1, 1'b1, '{16'hFFFF, 16'sh7FFF, 16'sh8000}, 5'd1}},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0000, 16'sh8000, 16'sh7FFF}}, 1'b1,
        '{1'b1, 1'b1, '{16'hFFFF, 16'sh7FFF, 16'sh8000}, 5'd2}},
      '{'{bhq_pkg::CMD_POP,  '{16'hFFFF, 16'shFFFF, 16'shFFFF}}, 1'b1,
        '{1'b1, 1'b1, '{16'h0000, 16'sh8000, 16'sh7FFF}, 5'd1}},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0001, 16'sh8000, 16'sh0000}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0002, 16'shFFFF, 16'shFFFF}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'hA5A5, 16'sh7FFF, 16'sh5A5A}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0004, 16'sh0100, 16'sh0001}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0005, 16'sh0100, 16'sh0002}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0006, 16'sh0100, 16'sh0003}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0007, 16'sh0000, 16'sh0004}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0008, 16'sh0100, 16'sh0005}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h0009, 16'sh0200, 16'sh0006}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h000A, 16'sh0200, 16'sh0007}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h000B, 16'sh0001, 16'sh0008}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h000C, 16'sh0100, 16'sh0009}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h000D, 16'sh7FFE, 16'sh000A}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h000E, 16'sh0200, 16'sh000B}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h000F, 16'sh0100, 16'sh000C}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_PUSH, '{16'h1234, 16'sh7FFF, 16'sh0001}}, 1'b1,
        '{1'b0, 1'b1, '{16'hA5A5, 16'sh7FFF, 16'sh5A5A}, 5'd16}},
      '{'{bhq_pkg::CMD_POP,  '{16'h0000, 16'sh0000, 16'sh0000}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_POP,  '{16'h0000, 16'sh0000, 16'sh0000}}, 1'b0, '0},
      '{'{bhq_pkg::CMD_POP,  '{16'h0000, 16'sh0000, 16'sh0000}}, 1'b0, '0}
   };

   function automatic bhq_pkg::result_type apply_to_heap(heap_request_type r);
      bhq_pkg::result_type res;
      bhq_pkg::entry_type  moved;
      int unsigned         at;
      int unsigned         left;
      int unsigned         big;
      res = '0;
      if (r.cmd == bhq_pkg::CMD_PUSH) begin
         if (heap_count < HEAP_DEPTH) begin
            heap_count++;
            heap_slots[heap_count] = r.item;
            at = heap_count;
            while (at > 1 &&
                   $signed(heap_slots[at].prim) > $signed(heap_slots[at / 2].prim)) begin
               moved = heap_slots[at];
               heap_slots[at] = heap_slots[at / 2];
               heap_slots[at / 2] = moved;
               at = at / 2;
            end
            res.ok = 1'b1;
         end
      end else if (heap_count > 0) begin
         heap_slots[1] = heap_slots[heap_count];
         heap_count--;
         at = 1;
         while (2 * at <= heap_count) begin
            left = 2 * at;
            if (left + 1 > heap_count ||
                $signed(heap_slots[left].prim) > $signed(heap_slots[left + 1].prim))
               big = left;
            else
               big = left + 1;
            if ($signed(heap_slots[at].prim) < $signed(heap_slots[big].prim)) begin
               moved = heap_slots[at];
               heap_slots[at] = heap_slots[big];
               heap_slots[big] = moved;
               at = big;
            end else begin
               break;
            end
         end
         res.ok = 1'b1;
      end
      if (heap_count > 0) begin
         res.head_valid = 1'b1;
         res.head = heap_slots[1];
      end
      res.count = bhq_pkg::COUNT_OUT_W'(heap_count);
      return res;
   endfunction

   function automatic heap_request_type random_request(int unsigned push_pct);
      heap_request_type r;
      r.cmd = ($urandom_range(99) < push_pct) ? bhq_pkg::CMD_PUSH : bhq_pkg::CMD_POP;
      r.item.tag = 16'($urandom);
      r.item.sec = 16'($urandom);
      case ($urandom_range(2))
         0: r.item.prim = 16'($urandom);
         1: r.item.prim = 16'($urandom_range(4)) - 16'd2;
         default: begin
            case ($urandom_range(3))
               0: r.item.prim = 16'sh7FFF;
               1: r.item.prim = 16'sh7FFE;
               2: r.item.prim = 16'sh8000;
               default: r.item.prim = 16'sh8001;
            endcase
         end
      endcase
      return r;
   endfunction

   task automatic send_request(heap_request_type r, logic known,
                               bhq_pkg::result_type want);
      bhq_pkg::result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.cmd                <= r.cmd;
      req_chan.item_tag           <= r.item.tag;
      req_chan.primary_priority   <= r.item.prim;
      req_chan.secondary_priority <= r.item.sec;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = apply_to_heap(r);
      rsp_expected_q.push_back(known ? want : predicted);
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (rsp_expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_run(int unsigned items);
      int unsigned n;
      int unsigned push_pct;
      for (n = 0; n < items; n++) begin
         // swing between filling, mixing and emptying the queue
         case ((n / 50) % 4)
            0: push_pct = 85;
            2: push_pct = 15;
            default: push_pct = 50;
         endcase
         send_request(random_request(push_pct), 1'b0, '0);
      end
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      bhq_pkg::result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (rsp_expected_q.size() == 0) begin
            $display("%0t: response expected none, got count %0d", $time,
                     rsp_chan.entry_count_out);
            mismatches++;
         end else begin
            want = rsp_expected_q.pop_front();
            check_field("ok", want.ok, rsp_chan.ok);
            check_field("head_valid", want.head_valid, rsp_chan.head_valid);
            check_field("head_tag", want.head.tag, rsp_chan.head_tag);
            check_field("head_primary", $signed(want.head.prim),
                        $signed(rsp_chan.head_primary));
            check_field("head_secondary", $signed(want.head.sec),
                        $signed(rsp_chan.head_secondary));
            check_field("entry_count_out", want.count, rsp_chan.entry_count_out);
         end
      end
   end

   initial begin : rsp_side
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned i;
      int unsigned phase;
      reset                       <= 1'b1;
      req_chan.valid              <= 1'b0;
      req_chan.cmd                <= bhq_pkg::CMD_PUSH;
      req_chan.item_tag           <= '0;
      req_chan.primary_priority   <= '0;
      req_chan.secondary_priority <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 10;
               recv_stall_pct = 10;
            end
         endcase
         send_random_run(PHASE_ITEMS);
         // pause until every pending response is back
         if (phase == 1)
            drain_responses();
      end

      // hold responses off while requests keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      send_random_run(PRESSURE_ITEMS);

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && rsp_expected_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
